>>> rtl/quadric_surface_eval_and_root_defines.svh
// ---------------------------------------------------------------------------
// Quadric evaluator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef QUADRIC_SURFACE_EVAL_AND_ROOT_DEFINES_SVH
`define QUADRIC_SURFACE_EVAL_AND_ROOT_DEFINES_SVH

// same-cycle implication
`define QSR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QSR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/qsr_pkg.sv
// ---------------------------------------------------------------------------
// Quadric evaluator package
// Payload types, coefficient bundle, queue record and shared codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package qsr_pkg;

  localparam int COORD_W = 16;
  localparam int COEF_W  = 16;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int QV_W = 40;
  localparam int GR_W = 32;
  localparam int RZ_W = 16;

  // solve path widths
  localparam int B_W     = 30;
  localparam int DELTA_W = 60;

  localparam logic [CFG_IDX_W-1:0] REG_XX_YY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZZ_XY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_XZ_YZ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_XY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_ZC  = 3'd4;
  localparam logic [CFG_W-1:0]     CFG_RESET   = 32'h1000_1000;

  localparam logic [1:0] ST_VALUE  = 2'd0;
  localparam logic [1:0] ST_ROOT   = 2'd1;
  localparam logic [1:0] ST_NOROOT = 2'd2;
  localparam logic [1:0] ST_DEGEN  = 2'd3;

  localparam logic [2:0] K_EVAL   = 3'd0;
  localparam logic [2:0] K_DEGEN  = 3'd1;
  localparam logic [2:0] K_NOROOT = 3'd2;
  localparam logic [2:0] K_DOUBLE = 3'd3;
  localparam logic [2:0] K_TWO    = 3'd4;

  typedef struct packed {
    logic                      opcode;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic signed [QV_W-1:0] quad_value;
    logic signed [GR_W-1:0] grad_x;
    logic signed [GR_W-1:0] grad_y;
    logic signed [GR_W-1:0] grad_z;
    logic signed [RZ_W-1:0] root_z;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] axx;
    logic signed [COEF_W-1:0] ayy;
    logic signed [COEF_W-1:0] azz;
    logic signed [COEF_W-1:0] sxy;
    logic signed [COEF_W-1:0] sxz;
    logic signed [COEF_W-1:0] syz;
    logic signed [COEF_W-1:0] bx;
    logic signed [COEF_W-1:0] by;
    logic signed [COEF_W-1:0] bz;
    logic signed [COEF_W-1:0] cc;
  } coef_t;

  // classified item as handed from front to back
  typedef struct packed {
    logic [2:0]               kind;
    logic signed [B_W-1:0]    b;
    logic signed [COEF_W-1:0] azz;
    logic [DELTA_W-1:0]       delta;
    logic [QV_W-1:0]          quad_value;
    logic [GR_W-1:0]          grad_x;
    logic [GR_W-1:0]          grad_y;
    logic [GR_W-1:0]          grad_z;
  } rec_t;

endpackage

>>> rtl/qsr_front.sv
// ---------------------------------------------------------------------------
// Quadric evaluator front end
// Four-stage multiply/add pipe: evaluates Q and gradient, forms the z
// quadratic and its discriminant, and classifies each item for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module qsr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  qsr_pkg::item_t  item,
  input  qsr_pkg::coef_t  coef,
  output logic            push,
  output qsr_pkg::rec_t   push_rec,
  input  logic            q_full
);
  import qsr_pkg::*;

  localparam int SQ_W  = 2 * COORD_W;
  localparam int P_W   = COEF_W + SQ_W;
  localparam int L_W   = COEF_W + COORD_W;
  localparam int Q_W   = 52;
  localparam int G_W   = 36;
  localparam int C_W   = 36;
  localparam int BB_W  = 2 * B_W;
  localparam int AC_W  = COEF_W + C_W;
  localparam int DL_W  = DELTA_W + 2;

  function automatic logic [QV_W-1:0] sat_qv(input logic signed [Q_W-1:0] v);
    logic [Q_W-QV_W:0] hi;
    hi = v[Q_W-1:QV_W-1];
    if (&hi || ~|hi) return v[QV_W-1:0];
    return v[Q_W-1] ? {1'b1, {(QV_W-1){1'b0}}} : {1'b0, {(QV_W-1){1'b1}}};
  endfunction

  function automatic logic [GR_W-1:0] sat_gr(input logic signed [G_W-1:0] v);
    logic [G_W-GR_W:0] hi;
    hi = v[G_W-1:GR_W-1];
    if (&hi || ~|hi) return v[GR_W-1:0];
    return v[G_W-1] ? {1'b1, {(GR_W-1){1'b0}}} : {1'b0, {(GR_W-1){1'b1}}};
  endfunction

  logic adv;
  logic v1, v2, v3, v4;

  logic                      op1;
  logic signed [COORD_W-1:0] x1, y1, z1;
  logic signed [SQ_W-1:0]    xx1, yy1, zz1, xy1, xz1, yz1;

  logic                   op2, dg2;
  logic signed [P_W-1:0]  pxx, pyy, pzz, pxy, pxz, pyz;
  logic signed [L_W-1:0]  lx, ly, lz;
  logic signed [L_W-1:0]  gaxx, gayy, gazz, gsxy_x, gsxy_y, gsxz_x, gsxz_z, gsyz_y, gsyz_z;

  logic signed [Q_W-1:0]  q_n, c_n;
  logic signed [G_W-1:0]  b_n, gx_n, gy_n, gz_n;

  logic                   op3, dg3;
  logic signed [Q_W-1:0]  q3;
  logic signed [G_W-1:0]  gx3, gy3, gz3;
  logic signed [B_W-1:0]  b3;
  logic signed [C_W-1:0]  c3;

  logic                   op4, dg4;
  logic [QV_W-1:0]        qv4;
  logic [GR_W-1:0]        gx4, gy4, gz4;
  logic signed [B_W-1:0]  b4;
  logic signed [BB_W-1:0] bb4;
  logic signed [AC_W-1:0] ac4;
  logic signed [DL_W-1:0] delta;

  assign adv        = !v4 || !q_full;
  assign item_stall = !adv;
  assign push       = v4 && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // coordinate products
  always_ff @(posedge clk) begin
    if (adv) begin
      op1 <= item.opcode;
      x1  <= item.pos_x;
      y1  <= item.pos_y;
      z1  <= item.pos_z;
      xx1 <= SQ_W'(item.pos_x * item.pos_x);
      yy1 <= SQ_W'(item.pos_y * item.pos_y);
      zz1 <= SQ_W'(item.pos_z * item.pos_z);
      xy1 <= SQ_W'(item.pos_x * item.pos_y);
      xz1 <= SQ_W'(item.pos_x * item.pos_z);
      yz1 <= SQ_W'(item.pos_y * item.pos_z);
    end
  end

  // coefficient products
  always_ff @(posedge clk) begin
    if (adv) begin
      op2    <= op1;
      dg2    <= coef.azz == '0;
      pxx    <= P_W'(coef.axx * xx1);
      pyy    <= P_W'(coef.ayy * yy1);
      pzz    <= P_W'(coef.azz * zz1);
      pxy    <= P_W'(coef.sxy * xy1);
      pxz    <= P_W'(coef.sxz * xz1);
      pyz    <= P_W'(coef.syz * yz1);
      lx     <= L_W'(coef.bx * x1);
      ly     <= L_W'(coef.by * y1);
      lz     <= L_W'(coef.bz * z1);
      gaxx   <= L_W'(coef.axx * x1);
      gayy   <= L_W'(coef.ayy * y1);
      gazz   <= L_W'(coef.azz * z1);
      gsxy_x <= L_W'(coef.sxy * x1);
      gsxy_y <= L_W'(coef.sxy * y1);
      gsxz_x <= L_W'(coef.sxz * x1);
      gsxz_z <= L_W'(coef.sxz * z1);
      gsyz_y <= L_W'(coef.syz * y1);
      gsyz_z <= L_W'(coef.syz * z1);
    end
  end

  // sums: Q and c carry 28 fraction bits, gradient and b carry 20
  always_comb begin
    q_n = Q_W'(pxx) + Q_W'(pyy) + Q_W'(pzz) + Q_W'(pxy) + Q_W'(pxz) + Q_W'(pyz)
        + ((Q_W'(lx) + Q_W'(ly) + Q_W'(lz)) <<< 8) + (Q_W'(coef.cc) <<< 16);
    c_n = Q_W'(pxx) + Q_W'(pyy) + Q_W'(pxy)
        + ((Q_W'(lx) + Q_W'(ly)) <<< 8) + (Q_W'(coef.cc) <<< 16);
    b_n = G_W'(gsxz_x) + G_W'(gsyz_y) + (G_W'(coef.bz) <<< 8);
    gx_n = (G_W'(gaxx) <<< 1) + G_W'(gsxy_y) + G_W'(gsxz_z) + (G_W'(coef.bx) <<< 8);
    gy_n = G_W'(gsxy_x) + (G_W'(gayy) <<< 1) + G_W'(gsyz_z) + (G_W'(coef.by) <<< 8);
    gz_n = G_W'(gsxz_x) + G_W'(gsyz_y) + (G_W'(gazz) <<< 1) + (G_W'(coef.bz) <<< 8);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op3 <= op2;
      dg3 <= dg2;
      q3  <= q_n;
      gx3 <= gx_n;
      gy3 <= gy_n;
      gz3 <= gz_n;
      b3  <= B_W'(b_n >>> 4);
      c3  <= C_W'(c_n >>> 12);
    end
  end

  // rounding, saturation, b^2 and a*c
  always_ff @(posedge clk) begin
    if (adv) begin
      op4 <= op3;
      dg4 <= dg3;
      qv4 <= sat_qv((q3 + Q_W'(2048)) >>> 12);
      gx4 <= sat_gr((gx3 + G_W'(8)) >>> 4);
      gy4 <= sat_gr((gy3 + G_W'(8)) >>> 4);
      gz4 <= sat_gr((gz3 + G_W'(8)) >>> 4);
      b4  <= b3;
      bb4 <= BB_W'(b3 * b3);
      ac4 <= AC_W'(coef.azz * c3);
    end
  end

  always_comb begin
    delta = DL_W'(bb4) - (DL_W'(ac4) <<< 2);
    push_rec            = '0;
    push_rec.b          = b4;
    push_rec.azz        = coef.azz;
    push_rec.delta      = delta[DELTA_W-1:0];
    push_rec.quad_value = qv4;
    push_rec.grad_x     = gx4;
    push_rec.grad_y     = gy4;
    push_rec.grad_z     = gz4;
    if (!op4)                push_rec.kind = K_EVAL;
    else if (dg4)            push_rec.kind = K_DEGEN;
    else if (delta[DL_W-1])  push_rec.kind = K_NOROOT;
    else if (delta == '0)    push_rec.kind = K_DOUBLE;
    else                     push_rec.kind = K_TWO;
  end

endmodule

>>> rtl/qsr_queue.sv
// ---------------------------------------------------------------------------
// Quadric evaluator decoupling queue
// Four-entry FIFO of classified items between front and back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module qsr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  qsr_pkg::rec_t  push_rec,
  output logic           full,
  input  logic           pop,
  output qsr_pkg::rec_t  pop_rec,
  output logic           empty
);
  import qsr_pkg::*;
  `include "quadric_surface_eval_and_root_defines.svh"

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  rec_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full    = count == (PTR_W+1)'(DEPTH);
  assign empty   = count == '0;
  assign pop_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `QSR_ASSERT_IMP(a_no_overflow, push, !full || pop, "queue overflow")
  `QSR_ASSERT_IMP(a_no_underflow, pop, !empty, "queue underflow")
  `QSR_ASSERT_NXT(a_count_bound, push && !pop && count == (PTR_W+1)'(DEPTH-1), full, "queue count")

endmodule

>>> rtl/qsr_back.sv
// ---------------------------------------------------------------------------
// Quadric evaluator back end
// Pipelined integer square root and two restoring divider lanes for the z
// roots, followed by an output register that issues one or two results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module qsr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  output logic             pop,
  input  qsr_pkg::rec_t    pop_rec,
  output logic             res_valid,
  input  logic             res_stall,
  output qsr_pkg::result_t res
);
  import qsr_pkg::*;
  `include "quadric_surface_eval_and_root_defines.svh"

  localparam int ROOT_W = DELTA_W / 2;
  localparam int REM_W  = ROOT_W + 4;
  localparam int NUM_W  = ROOT_W + 2;
  localparam int N_W    = NUM_W + 4;
  localparam int D_W    = COEF_W + 1;
  localparam int DQ_W   = 17;
  localparam int NSTG   = ROOT_W + 1 + DQ_W;
  localparam logic [RZ_W-1:0] RZ_MAX = {1'b0, {(RZ_W-1){1'b1}}};
  localparam logic [RZ_W-1:0] RZ_MIN = {1'b1, {(RZ_W-1){1'b0}}};

  typedef struct packed {
    rec_t              rec;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [DELTA_W-1:0] rad;
    logic [N_W-1:0]    r1;
    logic [N_W-1:0]    r2;
    logic [DQ_W-1:0]   q1;
    logic [DQ_W-1:0]   q2;
    logic [D_W-1:0]    dmag;
    logic              neg1;
    logic              neg2;
    logic              ovf1;
    logic              ovf2;
  } bk_t;

  // stages below ROOT_W take one root digit, stage ROOT_W sets up the
  // division, the rest each produce one quotient bit in both lanes
  function automatic bk_t stage_op(input bk_t s, input int j);
    bk_t o;
    logic [REM_W-1:0] remx;
    logic [REM_W-1:0] trial;
    logic signed [NUM_W-1:0] sv, bs, n1, n2;
    logic [NUM_W-1:0] m1, m2;
    logic signed [D_W-1:0] az, am;
    logic [N_W-1:0] dsh;
    int i;
    o = s;
    if (j < ROOT_W) begin
      remx  = {s.rem[REM_W-3:0], s.rad[DELTA_W-1 -: 2]};
      trial = REM_W'({s.root, 2'b01});
      if (remx >= trial) begin
        o.rem  = remx - trial;
        o.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
        o.rem  = remx;
        o.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      o.rad = s.rad << 2;
    end else if (j == ROOT_W) begin
      sv = {2'b00, s.root};
      bs = NUM_W'(s.rec.b);
      n1 = sv - bs;
      n2 = -sv - bs;
      m1 = n1[NUM_W-1] ? -n1 : n1;
      m2 = n2[NUM_W-1] ? -n2 : n2;
      az = D_W'(s.rec.azz);
      am = az[D_W-1] ? -az : az;
      o.dmag = {am[D_W-2:0], 1'b0};
      o.r1   = {m1, 4'b0000};
      o.r2   = {m2, 4'b0000};
      o.q1   = '0;
      o.q2   = '0;
      o.neg1 = n1[NUM_W-1] ^ s.rec.azz[COEF_W-1];
      o.neg2 = n2[NUM_W-1] ^ s.rec.azz[COEF_W-1];
      // quotient of 2^17 or more saturates anyway
      o.ovf1 = o.r1 >= (N_W'(o.dmag) << DQ_W);
      o.ovf2 = o.r2 >= (N_W'(o.dmag) << DQ_W);
    end else begin
      i   = DQ_W - 1 - (j - ROOT_W - 1);
      dsh = N_W'(s.dmag) << i;
      if (s.r1 >= dsh) begin
        o.r1    = s.r1 - dsh;
        o.q1[i] = 1'b1;
      end
      if (s.r2 >= dsh) begin
        o.r2    = s.r2 - dsh;
        o.q2[i] = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic logic [RZ_W-1:0] fin(input logic [DQ_W-1:0] m, input logic neg,
                                          input logic ovf);
    logic [RZ_W-1:0] r;
    if (!neg) begin
      r = (ovf || m > DQ_W'(RZ_MAX)) ? RZ_MAX : m[RZ_W-1:0];
    end else begin
      r = (ovf || m > DQ_W'(RZ_MIN)) ? RZ_MIN : RZ_W'(-m[RZ_W-1:0]);
    end
    return r;
  endfunction

  function automatic result_t build(input bk_t t, input logic sec);
    result_t r;
    r      = '0;
    r.last = 1'b1;
    case (t.rec.kind)
      K_EVAL: begin
        r.status     = ST_VALUE;
        r.quad_value = t.rec.quad_value;
        r.grad_x     = t.rec.grad_x;
        r.grad_y     = t.rec.grad_y;
        r.grad_z     = t.rec.grad_z;
      end
      K_DEGEN:  r.status = ST_DEGEN;
      K_NOROOT: r.status = ST_NOROOT;
      K_DOUBLE: begin
        r.status = ST_ROOT;
        r.root_z = fin(t.q1, t.neg1, t.ovf1);
      end
      K_TWO: begin
        r.status = ST_ROOT;
        r.root_z = sec ? fin(t.q2, t.neg2, t.ovf2) : fin(t.q1, t.neg1, t.ovf1);
        r.last   = sec;
      end
      default: r.status = ST_DEGEN;
    endcase
    return r;
  endfunction

  bk_t  head;
  bk_t  ps [NSTG];
  logic pv [NSTG];
  logic adv, sec_phase, two, out_free, emit, tail_done;

  always_comb begin
    head     = '0;
    head.rec = pop_rec;
    head.rad = pop_rec.delta;
  end

  assign two       = ps[NSTG-1].rec.kind == K_TWO;
  assign out_free  = !res_valid || !res_stall;
  assign emit      = pv[NSTG-1] && out_free;
  assign tail_done = emit && (!two || sec_phase);
  assign adv       = !pv[NSTG-1] || tail_done;
  assign pop       = adv && !empty;

  for (genvar j = 0; j < NSTG; j++) begin : g_stg
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          pv[j] <= 1'b0;
        end else if (adv) begin
          pv[j] <= pop;
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          ps[j] <= stage_op(head, j);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) begin
          pv[j] <= 1'b0;
        end else if (adv) begin
          pv[j] <= pv[j-1];
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          ps[j] <= stage_op(ps[j-1], j);
        end
      end
    end
  end

  // output register; a two-root item holds the tail for a second transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      sec_phase <= 1'b0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
        sec_phase <= two && !sec_phase;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= build(ps[NSTG-1], sec_phase);
    end
  end

  `QSR_ASSERT_IMP(a_mid_is_root, res_valid && !res.last, res.status == ST_ROOT, "non-final result not a root")
  `QSR_ASSERT_NXT(a_second_follows, res_valid && !res_stall && !res.last, res_valid && res.last && res.status == ST_ROOT, "second root missing")
  `QSR_ASSERT_IMP(a_sec_tail, sec_phase, pv[NSTG-1] && two, "second phase without two-root tail")

endmodule

>>> rtl/quadric_surface_eval_and_root.sv
// Stages: 4 front stages, queue, 30 square-root and 18 divide stages,
//   output register.
// Throughput: one item per cycle for evaluate, degenerate, no-root and single-root
//   items when res_stall is low; a two-root item gives its two roots in turn.
// Reset (rst, synchronous): empties pipes and queue, coefficients go to 1.0 : 1.0.
// ---------------------------------------------------------------------------
// Quadric surface evaluator and z-root solver
// Coefficient registers, front end, decoupling queue and back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module quadric_surface_eval_and_root (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  qsr_pkg::item_t                    item,
  output logic                              res_valid,
  input  logic                              res_stall,
  output qsr_pkg::result_t                  res,
  input  logic                              cfg_we,
  input  logic [qsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qsr_pkg::CFG_W-1:0]         cfg_data
);
  import qsr_pkg::*;

  logic [CFG_W-1:0] quad_xx_yy, quad_zz_xy, quad_xz_yz, lin_x_y, lin_z_const;
  coef_t coef;
  logic  push, q_full, pop, q_empty;
  rec_t  push_rec, pop_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      quad_xx_yy  <= CFG_RESET;
      quad_zz_xy  <= CFG_RESET;
      quad_xz_yz  <= CFG_RESET;
      lin_x_y     <= CFG_RESET;
      lin_z_const <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_XX_YY:  quad_xx_yy  <= cfg_data;
        REG_ZZ_XY:  quad_zz_xy  <= cfg_data;
        REG_XZ_YZ:  quad_xz_yz  <= cfg_data;
        REG_LIN_XY: lin_x_y     <= cfg_data;
        REG_LIN_ZC: lin_z_const <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.axx = quad_xx_yy[CFG_W-1 -: COEF_W];
    coef.ayy = quad_xx_yy[COEF_W-1:0];
    coef.azz = quad_zz_xy[CFG_W-1 -: COEF_W];
    coef.sxy = quad_zz_xy[COEF_W-1:0];
    coef.sxz = quad_xz_yz[CFG_W-1 -: COEF_W];
    coef.syz = quad_xz_yz[COEF_W-1:0];
    coef.bx  = lin_x_y[CFG_W-1 -: COEF_W];
    coef.by  = lin_x_y[COEF_W-1:0];
    coef.bz  = lin_z_const[CFG_W-1 -: COEF_W];
    coef.cc  = lin_z_const[COEF_W-1:0];
  end

  qsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .coef       (coef),
    .push       (push),
    .push_rec   (push_rec),
    .q_full     (q_full)
  );

  qsr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .empty    (q_empty)
  );

  qsr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .pop       (pop),
    .pop_rec   (pop_rec),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
